// File: design/fir_lowpass_30_tap_assert.svh
// Assertion macros for the filter's output stage module.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef FIR_LOWPASS_30_TAP_ASSERT_SVH
`define FIR_LOWPASS_30_TAP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FIRLP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define FIRLP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: design/firlp_pkg.sv
package firlp_pkg;

    localparam int TAP_COUNT      = 30;
    localparam int COEF_FRAC_BITS = 16;
    localparam int TAP_BASE_BITS  = 24;

    localparam int SAMPLE_W = 12;
    localparam int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int FILL_W   = $clog2(TAP_COUNT + 1);

    // Every tap is below 1/8, so the two top fraction bits are never needed.
    localparam int COEF_W = COEF_FRAC_BITS - 2;
    // The rounded taps sum to just under one, so one guard bit covers the sum with room to spare.
    localparam int ACC_W  = SAMPLE_W + COEF_FRAC_BITS + 1;

    localparam logic [SAMPLE_W-1:0] CODE_MAX = {SAMPLE_W{1'b1}};

    localparam int COEF_SHIFT = TAP_BASE_BITS - COEF_FRAC_BITS;
    localparam int COEF_HALF  = (COEF_SHIFT == 0) ? 0 : (1 << (COEF_SHIFT - 1));

    // Taps in units of 2^-24, tap 0 pairs with the newest sample.
    localparam logic [TAP_BASE_BITS-1:0] TAP_Q24 [TAP_COUNT] = '{
        24'd0,       24'd5916,    24'd24793,   24'd59709,   24'd114813,
        24'd194060,  24'd299826,  24'd431664,  24'd585500,  24'd753434,
        24'd924240,  24'd1084514, 24'd1220306, 24'd1318959, 24'd1370874,
        24'd1370874, 24'd1318959, 24'd1220306, 24'd1084514, 24'd924240,
        24'd753434,  24'd585500,  24'd431664,  24'd299826,  24'd194060,
        24'd114813,  24'd59709,   24'd24793,   24'd5916,    24'd0
    };

    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] acc;
    } firlp_res_t;

    // Rounds a tap to nearest in units of 2^-COEF_FRAC_BITS.
    function automatic logic [COEF_W-1:0] tap_coef(input int k);
        logic [TAP_BASE_BITS:0] q;
        q = {1'b0, TAP_Q24[k]};
        q = (q + (TAP_BASE_BITS + 1)'(COEF_HALF)) >> COEF_SHIFT;
        return q[COEF_W-1:0];
    endfunction

endpackage

// File: design/firlp_cell.sv
module firlp_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [firlp_pkg::COEF_W-1:0]   coef,
    input  logic [firlp_pkg::SAMPLE_W-1:0] sample,
    input  logic [firlp_pkg::ACC_W-1:0]    sum_in,
    output logic [firlp_pkg::ACC_W-1:0]    sum_out
);
    import firlp_pkg::*;

    logic [SAMPLE_W+COEF_W-1:0] prod;
    logic [ACC_W-1:0]           sum_reg;
    logic [ACC_W-1:0]           sum_next;

    // One tap of the transposed form: weight the new sample and add the
    // partial sum handed over by the older neighbor.
    assign prod     = {{COEF_W{1'b0}}, sample} * {{SAMPLE_W{1'b0}}, coef};
    assign sum_next = sum_in + ACC_W'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

// File: design/firlp_out.sv
module firlp_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  firlp_pkg::firlp_res_t         res,
    output logic                          skid_full,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [firlp_pkg::SAMPLE_W-1:0] out_data
);
    import firlp_pkg::*;

    `include "fir_lowpass_30_tap_assert.svh"

    localparam int SUM_W = ACC_W + 1;
    localparam int RND_W = SUM_W - COEF_FRAC_BITS;

    logic [SUM_W-1:0]    rnd_sum;
    logic [RND_W-1:0]    rnd_code;
    logic [SAMPLE_W-1:0] sat_code;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [SAMPLE_W-1:0] skid_data_reg, skid_data_next;
    logic                pop;

    // Round to nearest with ties up, then clamp to the code range.
    assign rnd_sum  = {1'b0, res.acc} + SUM_W'(1 << (COEF_FRAC_BITS - 1));
    assign rnd_code = rnd_sum[SUM_W-1:COEF_FRAC_BITS];
    assign sat_code = (rnd_code > RND_W'(CODE_MAX)) ? CODE_MAX : rnd_code[SAMPLE_W-1:0];

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = sat_code;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = sat_code;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `FIRLP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg,
        "skid entry held while the output register is empty")
    `FIRLP_ASSERT_ALWAYS(a_no_result_when_full, !skid_valid_reg || !res.valid,
        "new result arrived while both output entries are in use")
    `FIRLP_ASSERT_NEXT(a_stall_fills_skid,
        res.valid && out_valid_reg && !out_ready && !skid_valid_reg,
        skid_valid_reg, "stalled result was not parked in the skid entry")
    `FIRLP_ASSERT_NEXT(a_skid_moves_up, skid_valid_reg && out_ready,
        out_valid_reg && !skid_valid_reg && out_data_reg == $past(skid_data_reg),
        "skid entry did not move into the output register")

endmodule

// File: design/fir_lowpass_30_tap.sv
// Each result is registered into the output stage at the edge that accepts its sample.
// One sample per clock while s_axis_tready is high; the transposed tap chain keeps pace.
// The first 30 samples after reset only fill the filter and produce no result.
// A two-entry output stage keeps s_axis_tready high while one result waits downstream.
// Reset (rst_n low, asynchronous) clears the tap chain, the fill count and the output stage.
module fir_lowpass_30_tap (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [firlp_pkg::TDATA_W-1:0] s_axis_tdata,  // [11:0] sample, upper bits ignored
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [firlp_pkg::TDATA_W-1:0] m_axis_tdata   // [11:0] filtered_sample, rest zero
);
    import firlp_pkg::*;

    localparam logic [COEF_W-1:0] COEF0 = tap_coef(0);

    logic                        accept;
    logic                        filled;
    logic [SAMPLE_W-1:0]         sample;
    logic [FILL_W-1:0]           fill_count_reg, fill_count_next;
    logic [ACC_W-1:0]            chain [1:TAP_COUNT];
    logic [SAMPLE_W+COEF_W-1:0]  prod0;
    firlp_res_t                  res;
    logic                        skid_full;
    logic [SAMPLE_W-1:0]         out_code;

    // A transaction is taken whenever the output stage has a free entry.
    assign s_axis_tready = !skid_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sample        = s_axis_tdata[SAMPLE_W-1:0];

    // The fill count saturates at the tap count; from then on every
    // accepted sample yields one filtered code.
    assign filled          = (fill_count_reg == FILL_W'(TAP_COUNT));
    assign fill_count_next = (accept && !filled) ? fill_count_reg + 1'b1 : fill_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // Transposed-form chain: cell k holds the partial sum that starts at
    // tap k. The oldest cell is fed with zero. Since all cells reset to
    // zero, the chain matches a delay line that starts out cleared.
    assign chain[TAP_COUNT] = '0;

    for (genvar k = 1; k < TAP_COUNT; k++)
    begin : g_tap
        firlp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (accept),
            .coef    (tap_coef(k)),
            .sample  (sample),
            .sum_in  (chain[k+1]),
            .sum_out (chain[k])
        );
    end

    // Tap zero pairs with the incoming sample itself.
    assign prod0     = {{COEF_W{1'b0}}, sample} * {{SAMPLE_W{1'b0}}, COEF0};
    assign res.valid = accept && filled;
    assign res.acc   = chain[1] + ACC_W'(prod0);

    firlp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .skid_full (skid_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_code)
    );

    assign m_axis_tdata = TDATA_W'(out_code);

endmodule

// File: tb/sv/fir_lowpass_30_tap_test.sv
module fir_lowpass_30_tap_test;

    import firlp_pkg::*;

    // Items handed to the input stream, and how each stream side behaves while they go.
    typedef enum logic [2:0] {
        MODE_FLOW,          // both sides always ready
        MODE_PRESSURE,      // no gaps, but the sink holds off once for a long stretch
        MODE_SRC_GAPS,      // the source idles most cycles
        MODE_SINK_STALLS,   // the sink stalls most cycles
        MODE_BOTH           // both sides idle now and then
    } flow_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] code;
        flow_mode_t          mode;
    } sample_item_t;

    localparam int RANDOM_PER_MODE = 240;
    localparam int SINK_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 20;
    localparam int CYCLE_LIMIT      = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;     // [11:0] sample
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;          // [11:0] filtered_sample

    sample_item_t        pending_samples[$];
    logic [SAMPLE_W-1:0] expected_codes[$];

    // Filter state kept by the testbench: the newest sample sits in entry 0.
    logic [SAMPLE_W-1:0] delay_taps [TAP_COUNT];
    longint unsigned     coef_q [TAP_COUNT];
    int                  fill_count = 0;

    flow_mode_t          active_mode = MODE_FLOW;
    int                  hold_left = 0;
    logic                hold_done = 1'b0;
    int                  walk_level = 2048;

    int                  mismatches = 0;
    int                  accepted_samples = 0;
    int                  checked_codes = 0;
    int                  full_scale_codes = 0;

    fir_lowpass_30_tap DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // The low-pass taps in units of 2^-24. The response is symmetric, so only
    // the first half is listed and the second half mirrors it.
    function automatic longint unsigned tap_q24_at(input int k);
        int j;
        j = (k < TAP_COUNT / 2) ? k : TAP_COUNT - 1 - k;
        case (j)
            0:  return 0;
            1:  return 5916;
            2:  return 24793;
            3:  return 59709;
            4:  return 114813;
            5:  return 194060;
            6:  return 299826;
            7:  return 431664;
            8:  return 585500;
            9:  return 753434;
            10: return 924240;
            11: return 1084514;
            12: return 1220306;
            13: return 1318959;
            default: return 1370874;
        endcase
    endfunction

    function automatic int src_idle_pct(input flow_mode_t m);
        case (m)
            MODE_SRC_GAPS: return 78;
            MODE_BOTH:     return 28;
            default:       return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct(input flow_mode_t m);
        case (m)
            MODE_SINK_STALLS: return 78;
            MODE_BOTH:        return 28;
            default:          return 0;
        endcase
    endfunction

    // Shifts one accepted sample into the delay line. Once the line has been
    // filled, every sample yields one filtered code: the tap-weighted sum,
    // rounded to nearest with ties going up and clipped at full scale.
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] code);
        longint unsigned acc;
        longint unsigned rounded;
        acc = 0;
        for (int k = TAP_COUNT - 1; k > 0; k--)
            delay_taps[k] = delay_taps[k - 1];
        delay_taps[0] = code;
        if (fill_count < TAP_COUNT)
        begin
            fill_count++;
            return;
        end
        for (int k = 0; k < TAP_COUNT; k++)
            acc += longint'(delay_taps[k]) * coef_q[k];
        rounded = (acc + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
        if (rounded > CODE_MAX)
            rounded = CODE_MAX;
        expected_codes.push_back(rounded[SAMPLE_W-1:0]);
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] code, input flow_mode_t mode);
        sample_item_t item;
        item.code = code;
        item.mode = mode;
        pending_samples.push_back(item);
    endtask

    // Random samples shaped like a sensor stream: a slowly wandering level
    // with noise and sudden steps, mixed with uniform codes, codes at the
    // rails and codes near zero.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return SAMPLE_W'($urandom_range(CODE_MAX));
        if (sel < 65)
        begin
            walk_level = walk_level + int'($urandom_range(80)) - 40;
            if (walk_level < 0)
                walk_level = 0;
            if (walk_level > CODE_MAX)
                walk_level = CODE_MAX;
            return SAMPLE_W'(walk_level);
        end
        if (sel < 75)
        begin
            walk_level = $urandom_range(CODE_MAX);
            return SAMPLE_W'(walk_level);
        end
        if (sel < 88)
        begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return SAMPLE_W'(1);
                2:       return CODE_MAX - 1;
                default: return CODE_MAX;
            endcase
        end
        return SAMPLE_W'($urandom_range(31));
    endfunction

    // Source side. A new item is offered whenever the previous transaction
    // has completed or nothing was offered, unless the current mode calls for
    // an idle cycle. Each completed transaction feeds the predictor.
    always @(posedge clk or negedge rst_n)
    begin : drive_input
        sample_item_t item;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_sample(s_axis_tdata[SAMPLE_W-1:0]);
                accepted_samples++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct(pending_samples[0].mode))
                begin
                    item = pending_samples.pop_front();
                    active_mode   <= item.mode;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= TDATA_W'(item.code);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side. When the pressure mode starts, the sink refuses results for a
    // long stretch while the source keeps offering, so the output stage fills
    // and the block has to push back on its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (active_mode == MODE_PRESSURE && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= SINK_HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct(active_mode));
    end

    // Every completed output transaction is compared with the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin : check_output
        logic [SAMPLE_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("filtered_sample: expected no result, actual %0d",
                       m_axis_tdata[SAMPLE_W-1:0]);
                mismatches++;
            end
            else
            begin
                want = expected_codes.pop_front();
                checked_codes++;
                if (want == CODE_MAX)
                    full_scale_codes++;
                if (m_axis_tdata[SAMPLE_W-1:0] !== want)
                begin
                    $error("filtered_sample: expected %0d, actual %0d",
                           want, m_axis_tdata[SAMPLE_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            delay_taps[k] = '0;
            if (TAP_BASE_BITS == COEF_FRAC_BITS)
                coef_q[k] = tap_q24_at(k);
            else
                coef_q[k] = (tap_q24_at(k) + (64'd1 << (TAP_BASE_BITS - COEF_FRAC_BITS - 1)))
                            >> (TAP_BASE_BITS - COEF_FRAC_BITS);
        end

        // Directed part. Full-scale samples fill the line so that the first
        // results land on full scale. A lone full-scale sample among
        // zeros then walks the impulse through the early taps, and an
        // alternating pattern plus two checkerboard codes close it out.
        repeat (TAP_COUNT) queue_sample(CODE_MAX, MODE_FLOW);
        repeat (3) queue_sample(CODE_MAX, MODE_FLOW);
        queue_sample('0, MODE_FLOW);
        queue_sample(CODE_MAX, MODE_FLOW);
        repeat (5) queue_sample('0, MODE_FLOW);
        for (int n = 0; n < 6; n++)
            queue_sample((n % 2) ? CODE_MAX : '0, MODE_FLOW);
        queue_sample(12'h555, MODE_FLOW);
        queue_sample(12'haaa, MODE_FLOW);

        // Random part, one block of items per flow mode.
        for (int n = 0; n < RANDOM_PER_MODE * 5; n++)
            queue_sample(pick_sample(), flow_mode_t'(n / RANDOM_PER_MODE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until the source has nothing left, then until every predicted
        // result has come back, then a little longer for stray results.
        while (pending_samples.size() != 0 || s_axis_tvalid !== 1'b0)
            @(posedge clk);
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d samples under five flow patterns, one long sink hold-off included.",
                 accepted_samples);
        $display("Checked %0d filtered codes, %0d of them at full scale.",
                 checked_codes, full_scale_codes);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: fir_lowpass_30_tap.f
+incdir+design
design/firlp_pkg.sv
design/firlp_cell.sv
design/firlp_out.sv
design/fir_lowpass_30_tap.sv
tb/sv/fir_lowpass_30_tap_test.sv
